// File: design/rfs_pkg.sv
`timescale 1ns / 1ps

package rfs_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE = 8'hD3;
   localparam logic [23:0] CRC24Q_POLY   = 24'h864CFB;  // x^24 term implied
   localparam int unsigned LEN_WIDTH     = 10;
   localparam int unsigned COUNT_WIDTH   = 11;
   localparam int unsigned CRC_WIDTH     = 24;

   typedef enum logic [2:0] {
      ROLE_OUTSIDE  = 3'd0,
      ROLE_PREAMBLE = 3'd1,
      ROLE_HEADER   = 3'd2,
      ROLE_PAYLOAD  = 3'd3,
      ROLE_PARITY   = 3'd4
   } role_type;

   typedef struct packed {
      logic [7:0]           echo_byte;
      role_type             byte_role;
      logic                 frame_end;
      logic                 crc_good;
      logic [LEN_WIDTH-1:0] payload_length;
   } result_type;

endpackage

// File: design/rfs_crc_byte.sv
`timescale 1ns / 1ps

module rfs_crc_byte
   import rfs_pkg::*;
(
   input  logic [CRC_WIDTH-1:0] crc_in,
   input  logic [7:0]           data_byte,
   output logic [CRC_WIDTH-1:0] crc_out
);

   // msb-first crc-24q, one bit per step over the byte
   always_comb begin
      logic [CRC_WIDTH-1:0] acc;
      acc = crc_in ^ {data_byte, 16'h0000};
      for (int k = 0; k < 8; k++) begin
         if (acc[CRC_WIDTH-1]) begin
            acc = {acc[CRC_WIDTH-2:0], 1'b0} ^ CRC24Q_POLY;
         end else begin
            acc = {acc[CRC_WIDTH-2:0], 1'b0};
         end
      end
      crc_out = acc;
   end

endmodule

// File: design/rfs_deframer.sv
`timescale 1ns / 1ps

module rfs_deframer
   import rfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   logic                   in_frame_ff, in_frame_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [LEN_WIDTH-1:0]   frame_len_ff, frame_len_in;
   logic [CRC_WIDTH-1:0]   crc_accum_ff, crc_accum_in;
   logic [CRC_WIDTH-1:0]   parity_shift_ff, parity_shift_in;
   logic [1:0]             len_high_ff, len_high_in;

   logic [CRC_WIDTH-1:0]   crc_seed;
   logic [CRC_WIDTH-1:0]   crc_next;
   logic [COUNT_WIDTH-1:0] len_ext;
   role_type               role;
   logic                   end_flag;
   logic                   good_flag;

   assign crc_seed = in_frame_ff ? crc_accum_ff : '0;

   rfs_crc_byte u_crc (
      .crc_in    (crc_seed),
      .data_byte (rx_byte),
      .crc_out   (crc_next)
   );

   assign len_ext = {1'b0, frame_len_ff};

   always_comb begin
      in_frame_in     = in_frame_ff;
      byte_count_in   = byte_count_ff;
      frame_len_in    = frame_len_ff;
      crc_accum_in    = crc_accum_ff;
      parity_shift_in = parity_shift_ff;
      len_high_in     = len_high_ff;
      role            = ROLE_OUTSIDE;
      end_flag        = 1'b0;
      good_flag       = 1'b0;
      if (!in_frame_ff) begin
         if (rx_byte == PREAMBLE_BYTE) begin
            in_frame_in     = 1'b1;
            byte_count_in   = COUNT_WIDTH'(1);
            frame_len_in    = '0;
            len_high_in     = '0;
            parity_shift_in = '0;
            crc_accum_in    = crc_next;
            role            = ROLE_PREAMBLE;
         end
      end else begin
         priority if (byte_count_ff == COUNT_WIDTH'(1)) begin
            role         = ROLE_HEADER;
            len_high_in  = rx_byte[1:0];
            crc_accum_in = crc_next;
         end else if (byte_count_ff == COUNT_WIDTH'(2)) begin
            role         = ROLE_HEADER;
            frame_len_in = {len_high_ff, rx_byte};
            crc_accum_in = crc_next;
         end else if (byte_count_ff < len_ext + COUNT_WIDTH'(3)) begin
            role         = ROLE_PAYLOAD;
            crc_accum_in = crc_next;
         end else begin
            role            = ROLE_PARITY;
            parity_shift_in = {parity_shift_ff[CRC_WIDTH-9:0], rx_byte};
            // last of the three parity bytes closes the frame
            if (byte_count_ff >= len_ext + COUNT_WIDTH'(5)) begin
               end_flag    = 1'b1;
               good_flag   = (parity_shift_in == crc_accum_ff);
               in_frame_in = 1'b0;
            end
         end
         byte_count_in = end_flag ? '0 : byte_count_ff + COUNT_WIDTH'(1);
      end
   end

   assign result.echo_byte      = rx_byte;
   assign result.byte_role      = role;
   assign result.frame_end      = end_flag;
   assign result.crc_good       = good_flag;
   assign result.payload_length = frame_len_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_count_ff   <= '0;
         frame_len_ff    <= '0;
         crc_accum_ff    <= '0;
         parity_shift_ff <= '0;
         len_high_ff     <= '0;
      end else if (step) begin
         in_frame_ff     <= in_frame_in;
         byte_count_ff   <= byte_count_in;
         frame_len_ff    <= frame_len_in;
         crc_accum_ff    <= crc_accum_in;
         parity_shift_ff <= parity_shift_in;
         len_high_ff     <= len_high_in;
      end
   end

   a_hunt_count_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> byte_count_ff == '0)
      else $error("byte count not cleared while hunting");

   a_end_leaves_frame: assert property (@(posedge clock) disable iff (reset)
      step && end_flag |=> !in_frame_ff)
      else $error("frame end did not return to hunting");

   a_good_only_at_end: assert property (@(posedge clock) disable iff (reset)
      good_flag |-> end_flag && role == ROLE_PARITY)
      else $error("crc flag outside the frame-end byte");

   a_preamble_enters: assert property (@(posedge clock) disable iff (reset)
      step && role == ROLE_PREAMBLE |=> in_frame_ff && byte_count_ff == COUNT_WIDTH'(1))
      else $error("preamble did not open a frame");

endmodule

// File: design/rtcm3_frame_sync_crc24q_unit.sv
`timescale 1ns / 1ps

// rtcm 3 deframer: takes one stream byte per word and returns one tagged word per byte
// (echoed byte, role in the frame, frame-end mark, crc-24q pass flag, payload length).
// a byte is registered on entry, then the header/crc/parity logic updates the frame
// state and the tagged result is registered on the way out, and one byte is taken
// every cycle for as long as rsp_stall stays low. the limit on rate is the byte-wide
// crc-24q update, which is combinational. while the result register is held by
// rsp_stall the entry register still fills, then req_stall rises.

module rtcm3_frame_sync_crc24q_unit
   import rfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_echo_byte,
   output logic [2:0]           rsp_byte_role,
   output logic                 rsp_frame_end,
   output logic                 rsp_crc_good,
   output logic [LEN_WIDTH-1:0] rsp_payload_length
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_word_ff;
   result_type result;
   logic       out_free;
   logic       advance;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   rfs_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_echo_byte      = out_word_ff.echo_byte;
   assign rsp_byte_role      = out_word_ff.byte_role;
   assign rsp_frame_end      = out_word_ff.frame_end;
   assign rsp_crc_good       = out_word_ff.crc_good;
   assign rsp_payload_length = out_word_ff.payload_length;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !advance)
      else $error("result word overwritten while stalled");

   a_end_is_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_byte_role == ROLE_PARITY)
      else $error("frame end on a non-parity word");

   a_entry_drains: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |=> out_valid_ff)
      else $error("entry word not moved to the result register");

endmodule
